// ===== design/vtp_pkg.sv =====
package vtp_pkg;

	localparam int SCREEN_WIDTH  = 800;
	localparam int SCREEN_HEIGHT = 600;

	localparam logic signed [10:0] FOCAL = 11'sd300;
	localparam logic signed [38:0] HALF_Q16 = 39'sd32768;
	localparam logic signed [51:0] OFFSET_X = 52'(SCREEN_WIDTH * 32768);
	localparam logic signed [51:0] OFFSET_Y = 52'(SCREEN_HEIGHT * 32768);

	// divider geometry: quotient bits, numerator and divisor widths
	localparam int Q_W        = 40;
	localparam int NUM_W      = 52;
	localparam int DEN_W      = 38;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = Q_W / DIV_STEPS;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic signed [17:0] cos_yaw;
		logic signed [17:0] sin_yaw;
		logic signed [17:0] cos_pitch;
		logic signed [17:0] sin_pitch;
	} vtp_cfg_t;

	typedef struct packed {
		logic               vis;
		logic               neg_x;
		logic               neg_y;
		logic signed [31:0] depth;
	} vtp_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sh7FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -52'sh80000000)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== design/view_transform_project.sv =====
// Stages in order: rotation, divider input register, divider, projection, output register.
// One vertex per cycle when not stalled; the 10-stage restoring divider (4 quotient bits
// per stage, x and y in parallel lanes) and the rotation multipliers are fully pipelined.
// A stall with out_valid high freezes the whole pipeline in place; in_stall follows it.
// Reset (arst_n low) clears all valid bits and loads the camera at the origin, no rotation.
module view_transform_project (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               visible,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [31:0] view_depth
);

	typedef enum logic [2:0] {
		REG_CAM_X     = 3'd0,
		REG_CAM_Y     = 3'd1,
		REG_CAM_Z     = 3'd2,
		REG_COS_YAW   = 3'd3,
		REG_SIN_YAW   = 3'd4,
		REG_COS_PITCH = 3'd5,
		REG_SIN_PITCH = 3'd6,
		REG_NONE      = 3'd7
	} reg_idx_t;

	vtp_pkg::vtp_cfg_t  cfg_q;
	logic               adv;

	logic               rot_v;
	logic signed [35:0] x1;
	logic signed [38:0] y2, z2;

	logic                        v_s6;
	logic [vtp_pkg::NUM_W-1:0]   nx_s6, ny_s6;
	logic [vtp_pkg::DEN_W-1:0]   d_s6;
	vtp_pkg::vtp_side_t          sd_s6;
	logic signed [51:0]          ax, ay;

	logic                        div_v;
	logic [vtp_pkg::Q_W-1:0]     qx, qy;
	vtp_pkg::vtp_side_t          div_sd;
	logic signed [vtp_pkg::Q_W:0] sqx, sqy;

	logic                        v_s17;
	logic signed [51:0]          px_s17, py_s17;
	vtp_pkg::vtp_side_t          sd_s17;

	logic                        v_s18;
	logic                        vis_s18;
	logic signed [31:0]          sx_s18, sy_s18, dep_s18;

	assign cfg_ready = 1'b1;
	assign adv       = !(v_s18 && out_stall);
	assign in_stall  = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_x     <= '0;
			cfg_q.cam_y     <= '0;
			cfg_q.cam_z     <= '0;
			cfg_q.cos_yaw   <= 18'sd65536;
			cfg_q.sin_yaw   <= '0;
			cfg_q.cos_pitch <= 18'sd65536;
			cfg_q.sin_pitch <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CAM_X:     cfg_q.cam_x     <= cfg_data;
				REG_CAM_Y:     cfg_q.cam_y     <= cfg_data;
				REG_CAM_Z:     cfg_q.cam_z     <= cfg_data;
				REG_COS_YAW:   cfg_q.cos_yaw   <= cfg_data[17:0];
				REG_SIN_YAW:   cfg_q.sin_yaw   <= cfg_data[17:0];
				REG_COS_PITCH: cfg_q.cos_pitch <= cfg_data[17:0];
				REG_SIN_PITCH: cfg_q.sin_pitch <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	vtp_rotate u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.in_v   (in_valid),
		.vx     (vertex_x),
		.vy     (vertex_y),
		.vz     (vertex_z),
		.out_v  (rot_v),
		.x1     (x1),
		.y2     (y2),
		.z2     (z2)
	);

	// numerator magnitudes scaled by 2^16; sign goes around the divider
	always_comb begin
		ax = 52'(x1);
		ay = 52'(y2);
		if (x1[35]) ax = -ax;
		if (y2[38]) ay = -ay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (adv)
			v_s6 <= rot_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s6       <= ax[vtp_pkg::NUM_W-1:0] << 16;
			ny_s6       <= ay[vtp_pkg::NUM_W-1:0] << 16;
			d_s6        <= z2[vtp_pkg::DEN_W-1:0];
			sd_s6.vis   <= (z2 > vtp_pkg::HALF_Q16);
			sd_s6.neg_x <= x1[35];
			sd_s6.neg_y <= y2[38];
			sd_s6.depth <= vtp_pkg::sat32(52'(z2));
		end
	end

	vtp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s6),
		.num_x    (nx_s6),
		.num_y    (ny_s6),
		.den      (d_s6),
		.side_in  (sd_s6),
		.out_v    (div_v),
		.q_x      (qx),
		.q_y      (qy),
		.side_out (div_sd)
	);

	always_comb begin
		sqx = $signed({1'b0, qx});
		sqy = $signed({1'b0, qy});
		if (div_sd.neg_x) sqx = -sqx;
		if (div_sd.neg_y) sqy = -sqy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
		end else if (adv) begin
			v_s17 <= div_v;
			v_s18 <= v_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s17 <= 52'(sqx) * 52'(vtp_pkg::FOCAL);
			py_s17 <= 52'(sqy) * 52'(vtp_pkg::FOCAL);
			sd_s17 <= div_sd;

			vis_s18 <= sd_s17.vis;
			dep_s18 <= sd_s17.depth;
			// y axis flips on screen
			sx_s18  <= sd_s17.vis ? vtp_pkg::sat32(px_s17 + vtp_pkg::OFFSET_X) : '0;
			sy_s18  <= sd_s17.vis ? vtp_pkg::sat32(vtp_pkg::OFFSET_Y - py_s17) : '0;
		end
	end

	assign out_valid  = v_s18;
	assign visible    = vis_s18;
	assign screen_x   = sx_s18;
	assign screen_y   = sy_s18;
	assign view_depth = dep_s18;

endmodule

// ===== design/vtp_rotate.sv =====
module vtp_rotate (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  vtp_pkg::vtp_cfg_t       cfg,
	input  logic                    in_v,
	input  logic signed [31:0]      vx,
	input  logic signed [31:0]      vy,
	input  logic signed [31:0]      vz,
	output logic                    out_v,
	output logic signed [35:0]      x1,
	output logic signed [38:0]      y2,
	output logic signed [38:0]      z2
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [50:0] xc_s2, zs_s2, zc_s2, xs_s2;
	logic signed [32:0] dy_s2, dy_s3;
	logic signed [51:0] sum_x1, sum_z1;
	logic signed [35:0] x1_s3, z1_s3, x1_s4, x1_s5;
	logic signed [50:0] yc_s4, ys_s4;
	logic signed [53:0] zs_s4, zc_s4;
	logic signed [54:0] sum_y2, sum_z2;
	logic signed [38:0] y2_s5, z2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		sum_x1 = 52'(xc_s2) + 52'(zs_s2);
		sum_z1 = 52'(zc_s2) - 52'(xs_s2);
		sum_y2 = 55'(yc_s4) - 55'(zs_s4);
		sum_z2 = 55'(ys_s4) + 55'(zc_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= 33'(vx) - 33'(cfg.cam_x);
			dy_s1 <= 33'(vy) - 33'(cfg.cam_y);
			dz_s1 <= 33'(vz) - 33'(cfg.cam_z);

			xc_s2 <= 51'(dx_s1) * 51'(cfg.cos_yaw);
			zs_s2 <= 51'(dz_s1) * 51'(cfg.sin_yaw);
			zc_s2 <= 51'(dz_s1) * 51'(cfg.cos_yaw);
			xs_s2 <= 51'(dx_s1) * 51'(cfg.sin_yaw);
			dy_s2 <= dy_s1;

			// floor by arithmetic shift
			x1_s3 <= 36'(sum_x1 >>> 16);
			z1_s3 <= 36'(sum_z1 >>> 16);
			dy_s3 <= dy_s2;

			yc_s4 <= 51'(dy_s3) * 51'(cfg.cos_pitch);
			ys_s4 <= 51'(dy_s3) * 51'(cfg.sin_pitch);
			zs_s4 <= 54'(z1_s3) * 54'(cfg.sin_pitch);
			zc_s4 <= 54'(z1_s3) * 54'(cfg.cos_pitch);
			x1_s4 <= x1_s3;

			y2_s5 <= 39'(sum_y2 >>> 16);
			z2_s5 <= 39'(sum_z2 >>> 16);
			x1_s5 <= x1_s4;
		end
	end

	assign out_v = v_s5;
	assign x1    = x1_s5;
	assign y2    = y2_s5;
	assign z2    = z2_s5;

endmodule

// ===== design/vtp_div.sv =====
module vtp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_v,
	input  logic [vtp_pkg::NUM_W-1:0]         num_x,
	input  logic [vtp_pkg::NUM_W-1:0]         num_y,
	input  logic [vtp_pkg::DEN_W-1:0]         den,
	input  vtp_pkg::vtp_side_t                side_in,
	output logic                              out_v,
	output logic [vtp_pkg::Q_W-1:0]           q_x,
	output logic [vtp_pkg::Q_W-1:0]           q_y,
	output vtp_pkg::vtp_side_t                side_out
);

	localparam int NW = vtp_pkg::NUM_W;
	localparam int DW = vtp_pkg::DEN_W;
	localparam int QW = vtp_pkg::Q_W;
	localparam int NS = vtp_pkg::DIV_STAGES;

	// index 0 is the stage input, index k the register after stage k
	logic               v_sn    [0:NS];
	logic [DW-1:0]      rx_sn   [0:NS];
	logic [DW-1:0]      ry_sn   [0:NS];
	logic [NW-1:0]      nx_sn   [0:NS];
	logic [NW-1:0]      ny_sn   [0:NS];
	logic [DW-1:0]      d_sn    [0:NS];
	vtp_pkg::vtp_side_t sd_sn   [0:NS];

	// top bits of the numerator are below any valid divisor, so start there
	assign v_sn[0]  = in_v;
	assign rx_sn[0] = DW'(num_x[NW-1:QW]);
	assign ry_sn[0] = DW'(num_y[NW-1:QW]);
	assign nx_sn[0] = num_x << (NW - QW);
	assign ny_sn[0] = num_y << (NW - QW);
	assign d_sn[0]  = den;
	assign sd_sn[0] = side_in;

	for (genvar g = 0; g < NS; g++) begin : g_st
		logic [DW-1:0] rx, ry;
		logic [NW-1:0] nx, ny;
		logic [DW:0]   tx, ty;
		logic          gx, gy;

		always_comb begin
			rx = rx_sn[g];
			ry = ry_sn[g];
			nx = nx_sn[g];
			ny = ny_sn[g];
			tx = '0;
			ty = '0;
			gx = 1'b0;
			gy = 1'b0;
			for (int k = 0; k < vtp_pkg::DIV_STEPS; k++) begin
				tx = {rx, nx[NW-1]};
				ty = {ry, ny[NW-1]};
				gx = (tx >= {1'b0, d_sn[g]});
				gy = (ty >= {1'b0, d_sn[g]});
				nx = {nx[NW-2:0], gx};
				ny = {ny[NW-2:0], gy};
				rx = gx ? DW'(tx - {1'b0, d_sn[g]}) : tx[DW-1:0];
				ry = gy ? DW'(ty - {1'b0, d_sn[g]}) : ty[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sn[g+1] <= 1'b0;
			else if (adv)
				v_sn[g+1] <= v_sn[g];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rx_sn[g+1] <= rx;
				ry_sn[g+1] <= ry;
				nx_sn[g+1] <= nx;
				ny_sn[g+1] <= ny;
				d_sn[g+1]  <= d_sn[g];
				sd_sn[g+1] <= sd_sn[g];
			end
		end
	end

	assign out_v    = v_sn[NS];
	assign q_x      = nx_sn[NS][QW-1:0];
	assign q_y      = ny_sn[NS][QW-1:0];
	assign side_out = sd_sn[NS];

endmodule

// ===== tb/tb_view_transform_project.sv =====
`timescale 1ns / 100ps

module tb_view_transform_project;

	localparam int REG_CAM_X     = 0;
	localparam int REG_CAM_Y     = 1;
	localparam int REG_CAM_Z     = 2;
	localparam int REG_COS_YAW   = 3;
	localparam int REG_SIN_YAW   = 4;
	localparam int REG_COS_PITCH = 5;
	localparam int REG_SIN_PITCH = 6;
	localparam int REG_UNUSED    = 7;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int ONE_Q16       = 65536;

	typedef struct {
		logic        vis;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] depth;
	} screen_pt_t;

	class projection_scoreboard;
		longint cam_x, cam_y, cam_z, cy, sy, cp, sp;
		screen_pt_t pending[$];
		int errors;

		function new();
			cam_x = 0; cam_y = 0; cam_z = 0;
			cy = ONE_Q16; sy = 0; cp = ONE_Q16; sp = 0;
			errors = 0;
		endfunction

		function void write_reg(int idx, logic [31:0] d);
			case (idx)
				REG_CAM_X:     cam_x = longint'($signed(d));
				REG_CAM_Y:     cam_y = longint'($signed(d));
				REG_CAM_Z:     cam_z = longint'($signed(d));
				REG_COS_YAW:   cy = longint'($signed(d[17:0]));
				REG_SIN_YAW:   sy = longint'($signed(d[17:0]));
				REG_COS_PITCH: cp = longint'($signed(d[17:0]));
				REG_SIN_PITCH: sp = longint'($signed(d[17:0]));
				default: ;
			endcase
		endfunction

		function logic [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) return 32'h7FFFFFFF;
			if (v < -64'sd2147483648) return 32'h80000000;
			return v[31:0];
		endfunction

		function void note_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
			longint dx, dy, dz, x1, z1, y2, z2, nx, ny;
			screen_pt_t p;
			dx = longint'($signed(vx)) - cam_x;
			dy = longint'($signed(vy)) - cam_y;
			dz = longint'($signed(vz)) - cam_z;
			// >>> on longint floors
			x1 = (dx * cy + dz * sy) >>> 16;
			z1 = (dz * cy - dx * sy) >>> 16;
			y2 = (dy * cp - z1 * sp) >>> 16;
			z2 = (dy * sp + z1 * cp) >>> 16;
			p.vis = 0; p.sx = 0; p.sy = 0;
			if (z2 > 32768) begin
				nx = (x1 * 65536) / z2;
				ny = (y2 * 65536) / z2;
				p.vis = 1;
				p.sx = clamp32(nx * 300 + longint'(vtp_pkg::SCREEN_WIDTH) * 32768);
				p.sy = clamp32(-ny * 300 + longint'(vtp_pkg::SCREEN_HEIGHT) * 32768);
			end
			p.depth = clamp32(z2);
			pending = {pending, p};
		endfunction

		function void check_result(logic v, logic [31:0] x, logic [31:0] y, logic [31:0] d);
			screen_pt_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.vis) begin
				$error("visible: expected %0d, got %0d", e.vis, v); errors++;
			end
			if (x !== e.sx) begin
				$error("screen_x: expected %0d, got %0d", $signed(e.sx), $signed(x)); errors++;
			end
			if (y !== e.sy) begin
				$error("screen_y: expected %0d, got %0d", $signed(e.sy), $signed(y)); errors++;
			end
			if (d !== e.depth) begin
				$error("view_depth: expected %0d, got %0d", $signed(e.depth), $signed(d));
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall;
	logic signed [31:0] vertex_x, vertex_y, vertex_z;
	logic out_valid, out_stall, visible;
	logic signed [31:0] screen_x, screen_y, view_depth;

	projection_scoreboard sb;
	int idle_cycles;
	bit stall_on;
	bit quiet_rx;

	view_transform_project i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern and result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(visible, screen_x, screen_y, view_depth);
	end

	always @(negedge clk) begin
		if (quiet_rx)
			out_stall <= 0;
		else if ($urandom_range(0, 9) == 0)
			out_stall <= ~out_stall;
		else if (out_stall && $urandom_range(0, 2) == 0)
			out_stall <= 0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("view_transform_project test failed");
			$finish;
		end
	end

	task automatic write_cfg(int idx, logic [31:0] d);
		cfg_valid = 1;
		cfg_index = 3'(idx);
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit keep);
		in_valid = 1;
		vertex_x = x; vertex_y = y; vertex_z = z;
		do @(posedge clk); while (in_stall);
		sb.note_vertex(x, y, z);
		@(negedge clk);
		if (!keep) in_valid = 0;
	endtask

	task automatic drain();
		in_valid = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7FFFFFFF - $urandom_range(0, 3);
			2: return 32'h80000000 + $urandom_range(0, 3);
			default: return 32'($signed($urandom_range(0, 200 * ONE_Q16)) - 100 * ONE_Q16);
		endcase
	endfunction

	function automatic logic [31:0] rand_trig();
		case ($urandom_range(0, 4))
			0: return 32'($urandom());
			1: return ONE_Q16;
			2: return -ONE_Q16;
			default: return 32'($signed($urandom_range(0, 2 * ONE_Q16)) - ONE_Q16);
		endcase
	endfunction

	function automatic logic [31:0] rand_offset();
		return 32'($signed($urandom_range(0, 20 * ONE_Q16)) - 10 * ONE_Q16);
	endfunction

	// camera z at or behind the origin except in every third phase; yaw and pitch are random
	task automatic random_config(int phase);
		write_cfg(REG_CAM_X, (phase % 3 == 0) ? $urandom() : rand_offset());
		write_cfg(REG_CAM_Y, (phase % 3 == 0) ? $urandom() : rand_offset());
		write_cfg(REG_CAM_Z,
			(phase % 3 == 0) ? $urandom() : -32'($urandom_range(0, 200 * ONE_Q16)));
		write_cfg(REG_COS_YAW, rand_trig());
		write_cfg(REG_SIN_YAW, rand_trig());
		write_cfg(REG_COS_PITCH, rand_trig());
		write_cfg(REG_SIN_PITCH, rand_trig());
		write_cfg(REG_UNUSED, $urandom());
	endtask

	initial begin
		int burst;
		sb = new();
		arst_n = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; vertex_x = 0; vertex_y = 0; vertex_z = 0;
		out_stall = 0; quiet_rx = 0; idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: identity camera, depth edges, extremes
		send_vertex(0, 0, 32768, 0);
		send_vertex(0, 0, 32769, 0);
		send_vertex(ONE_Q16, -ONE_Q16, 2 * ONE_Q16, 0);
		send_vertex(32'h7FFFFFFF, 32'h80000000, 32769, 0);
		send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
		send_vertex(-5 * ONE_Q16, 3 * ONE_Q16, 10 * ONE_Q16, 1);
		send_vertex(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		drain();
		write_cfg(REG_CAM_X, 32'h80000000);
		write_cfg(REG_CAM_Y, 32'h7FFFFFFF);
		write_cfg(REG_CAM_Z, 32'h80000000);
		write_cfg(REG_COS_YAW, 32'h0001FFFF);
		write_cfg(REG_SIN_YAW, 32'h00020000);
		write_cfg(REG_COS_PITCH, 32'h00020000);
		write_cfg(REG_SIN_PITCH, 32'h0001FFFF);
		write_cfg(REG_UNUSED, 32'h12345678);
		send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
		send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
		send_vertex(0, 0, 0, 0);
		send_vertex(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 0);
		drain();
		write_cfg(REG_CAM_X, 0); write_cfg(REG_CAM_Y, 0); write_cfg(REG_CAM_Z, 0);
		write_cfg(REG_COS_YAW, -ONE_Q16); write_cfg(REG_SIN_YAW, 0);
		write_cfg(REG_COS_PITCH, 0); write_cfg(REG_SIN_PITCH, ONE_Q16);
		send_vertex(ONE_Q16, -ONE_Q16, 2 * ONE_Q16, 0);
		send_vertex(ONE_Q16, 10 * ONE_Q16, 0, 0);
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			random_config(phase);
			quiet_rx = (phase == 3);
			for (int n = 0; n < 150; ) begin
				burst = $urandom_range(1, 20);
				for (int k = 0; k < burst && n < 150; k++, n++)
					send_vertex(rand_coord(), rand_coord(), rand_coord(),
						k + 1 < burst && n + 1 < 150);
				if (phase != 3) begin
					in_valid = 0;
					repeat ($urandom_range(0, 6)) @(negedge clk);
				end
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("view_transform_project test passed");
		else
			$display("view_transform_project test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/vtp_pkg.sv
design/vtp_rotate.sv
design/vtp_div.sv
design/view_transform_project.sv
tb/tb_view_transform_project.sv
